// File: hdl/laead_pkg.sv
package laead_pkg;

  // Item commands carried on the slave-side tuser
  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_NONCE  = 3'd1;
  localparam logic [2:0] CMD_AD     = 3'd2;
  localparam logic [2:0] CMD_ENC    = 3'd3;
  localparam logic [2:0] CMD_DEC    = 3'd4;
  localparam logic [2:0] CMD_FINAL  = 3'd5;

  // Frame bits XORed into state word 1 ahead of each permutation but the one after start
  localparam logic [31:0] FRAME_NONCE = 32'h0000_0010;
  localparam logic [31:0] FRAME_AD    = 32'h0000_0030;
  localparam logic [31:0] FRAME_TEXT  = 32'h0000_0050;
  localparam logic [31:0] FRAME_FINAL = 32'h0000_0070;

  // 32 rounds per step: 1024 rounds = 32 steps, 640 rounds = 20 steps
  localparam int unsigned STEPS_LONG  = 1024 / 32;
  localparam int unsigned STEPS_SHORT = 640 / 32;
  localparam int unsigned STEP_W      = $clog2(STEPS_LONG);

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_TAG  = 1'b1;

  localparam int unsigned IN_TDATA_W = 104;

  typedef struct packed {
    logic       load;     // latch request payload, apply clear / frame bits
    logic       step;     // advance the state 32 rounds
    logic [1:0] key_idx;  // key word for this step
    logic       absorb;   // absorb the word, emit data result when needed
    logic       tag0;     // emit first tag word, reframe for the second pass
    logic       tag1;     // emit second tag word with compare result
    logic [2:0] cmd;      // command that the above acts on
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;       // output register can take a result this cycle
  } dp_status_t;

endpackage

// File: hdl/lightweight_aead_128.sv
// TinyJAMBU-128 authenticated cipher engine, one 32-bit word per request.
// Send a start request (tuser command 0), then nonce words, associated
// data words, encrypt or decrypt words and a finalize request; each acts on
// the current 128-bit state. The key is set through the write port (index 0
// key words 0/1, index 1 key words 2/3) while the engine is idle. The
// keyed feedback register advances 32 rounds per clock; a request is
// accepted, runs 1024 rounds (start, encrypt, decrypt) or 640 rounds
// (nonce, AD) and then its absorb step; finalize runs 1024 + 640 rounds
// and delivers the two tag words. Commands 6 and 7 are accepted and
// dropped. One request is in flight at a time; a result waits in the
// output register while the next request is accepted, and the engine
// holds at the absorb step or at either tag step only when a new result
// would overwrite one not yet taken.
module lightweight_aead_128 import laead_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // key write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [63:0]           cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] data_word, [34:32] byte_count, [98:35] expected_tag, [103:99] zero
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]            s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] result_data
  output logic [31:0]           m_axis_tdata,
  // [0] result_kind, [1] tag_match
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  laead_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  laead_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_tdata_i (s_axis_tdata),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser),
    .m_last_o   (m_axis_tlast)
  );

endmodule

// File: hdl/laead_datapath.sv
module laead_datapath import laead_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [63:0]           cfg_data_i,
  input  logic [IN_TDATA_W-1:0] in_tdata_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [31:0]           m_data_o,
  output logic [1:0]            m_user_o,
  output logic                  m_last_o
);

  logic [31:0] s_q [4];
  logic [31:0] s_d [4];
  logic [63:0] key_low_q, key_high_q;

  // Request payload
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic [63:0] expect_q;
  logic [31:0] tag0_q;

  // Output register
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_kind_q, out_last_q, out_match_q;

  logic [31:0] key_word, t47, t70, t85, t91, fb;
  logic [1:0]  short_len;
  logic [31:0] mask, w_masked, res;
  logic        out_free;

  always_comb begin
    unique case (cmd_i.key_idx)
      2'd0: key_word = key_low_q[31:0];
      2'd1: key_word = key_low_q[63:32];
      2'd2: key_word = key_high_q[31:0];
      2'd3: key_word = key_high_q[63:32];
      default: key_word = key_low_q[31:0];
    endcase
  end

  assign t47 = {s_q[2][14:0], s_q[1][31:15]};
  assign t70 = {s_q[3][5:0],  s_q[2][31:6]};
  assign t85 = {s_q[3][20:0], s_q[2][31:21]};
  assign t91 = {s_q[3][26:0], s_q[2][31:27]};
  assign fb  = s_q[0] ^ t47 ^ ~(t70 & t85) ^ t91 ^ key_word;

  // counts 1..3 are a short word; everything else is a full word
  assign short_len = cnt_q[2] ? 2'd0 : cnt_q[1:0];

  always_comb begin
    unique case (short_len)
      2'd1: mask = 32'h0000_00ff;
      2'd2: mask = 32'h0000_ffff;
      2'd3: mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign w_masked = word_q & mask;
  assign res      = (s_q[2] & mask) ^ w_masked;
  assign out_free = !out_valid_q || m_ready_i;
  assign status_o.out_free = out_free;

  always_comb begin
    s_d = s_q;
    if (cmd_i.load) begin
      unique case (cmd_i.cmd)
        CMD_START: begin
          s_d[0] = '0; s_d[1] = '0; s_d[2] = '0; s_d[3] = '0;
        end
        CMD_NONCE: s_d[1] = s_q[1] ^ FRAME_NONCE;
        CMD_AD:    s_d[1] = s_q[1] ^ FRAME_AD;
        CMD_ENC,
        CMD_DEC:   s_d[1] = s_q[1] ^ FRAME_TEXT;
        CMD_FINAL: s_d[1] = s_q[1] ^ FRAME_FINAL;
        default: ;
      endcase
    end else if (cmd_i.step) begin
      s_d[0] = s_q[1];
      s_d[1] = s_q[2];
      s_d[2] = s_q[3];
      s_d[3] = fb;
    end else if (cmd_i.absorb) begin
      unique case (cmd_i.cmd)
        CMD_NONCE: s_d[3] = s_q[3] ^ word_q;
        CMD_AD,
        CMD_ENC: begin
          s_d[3] = s_q[3] ^ w_masked;
          s_d[1] = s_q[1] ^ {30'd0, short_len};
        end
        CMD_DEC: begin
          s_d[3] = s_q[3] ^ res;
          s_d[1] = s_q[1] ^ {30'd0, short_len};
        end
        default: ;
      endcase
    end else if (cmd_i.tag0) begin
      s_d[1] = s_q[1] ^ FRAME_FINAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) s_q[i] <= '0;
      key_low_q  <= '0;
      key_high_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_q <= s_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
          CFG_KEY_HIGH: key_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((cmd_i.absorb && (cmd_i.cmd == CMD_ENC || cmd_i.cmd == CMD_DEC))
          || cmd_i.tag0 || cmd_i.tag1) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q   <= in_tdata_i[31:0];
      cnt_q    <= in_tdata_i[34:32];
      expect_q <= in_tdata_i[98:35];
    end
    if (cmd_i.absorb && (cmd_i.cmd == CMD_ENC || cmd_i.cmd == CMD_DEC)) begin
      out_data_q  <= res;
      out_kind_q  <= KIND_DATA;
      out_last_q  <= 1'b1;
      out_match_q <= 1'b0;
    end else if (cmd_i.tag0) begin
      tag0_q      <= s_q[2];
      out_data_q  <= s_q[2];
      out_kind_q  <= KIND_TAG;
      out_last_q  <= 1'b0;
      out_match_q <= 1'b0;
    end else if (cmd_i.tag1) begin
      out_data_q  <= s_q[2];
      out_kind_q  <= KIND_TAG;
      out_last_q  <= 1'b1;
      out_match_q <= ({s_q[2], tag0_q} == expect_q);
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_user_o  = {out_match_q, out_kind_q};
  assign m_last_o  = out_last_q;

endmodule

// File: hdl/laead_ctrl.sv
module laead_ctrl import laead_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] in_cmd_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PERM = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [2:0]        cmd_q, cmd_d;
  logic              long_q, long_d;
  logic              fin2_q, fin2_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step, needs_out, known_cmd;

  localparam logic [STEP_W-1:0] LAST_LONG  = STEP_W'(STEPS_LONG - 1);
  localparam logic [STEP_W-1:0] LAST_SHORT = STEP_W'(STEPS_SHORT - 1);

  assign last_step = (step_q == (long_q ? LAST_LONG : LAST_SHORT));
  assign needs_out = (cmd_q == CMD_ENC) || (cmd_q == CMD_DEC) || (cmd_q == CMD_FINAL);
  assign known_cmd = (in_cmd_i == CMD_START) || (in_cmd_i == CMD_NONCE) ||
                     (in_cmd_i == CMD_AD) || (in_cmd_i == CMD_ENC) ||
                     (in_cmd_i == CMD_DEC) || (in_cmd_i == CMD_FINAL);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    long_d  = long_q;
    fin2_d  = fin2_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.cmd     = cmd_q;
    cmd_o.key_idx = step_q[1:0];
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cmd = in_cmd_i;
        if (in_valid_i && known_cmd) begin
          cmd_o.load = 1'b1;
          cmd_d   = in_cmd_i;
          long_d  = !((in_cmd_i == CMD_NONCE) || (in_cmd_i == CMD_AD));
          fin2_d  = 1'b0;
          step_d  = '0;
          state_d = S_PERM;
        end
      end
      S_PERM: begin
        cmd_o.step = 1'b1;
        step_d = step_q + 1'b1;
        if (last_step) state_d = S_POST;
      end
      S_POST: begin
        if (!needs_out || status_i.out_free) begin
          if (cmd_q == CMD_FINAL && !fin2_q) begin
            cmd_o.tag0 = 1'b1;
            fin2_d  = 1'b1;
            long_d  = 1'b0;
            step_d  = '0;
            state_d = S_PERM;
          end else if (cmd_q == CMD_FINAL) begin
            cmd_o.tag1 = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.absorb = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_START;
      long_q  <= 1'b0;
      fin2_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      long_q  <= long_d;
      fin2_q  <= fin2_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: sim/lightweight_aead_128_tb.sv
// Self-checking bench for the word-serial AEAD engine.
// A sender process walks a short directed plan and then random sessions
// (start, three nonce words, AD words, encrypt or decrypt words, finalize),
// with some noise and broken sessions mixed in. Every accepted request is
// run through a local model of the cipher state; the results it produces
// are queued and checked in order against the master-side stream.
module lightweight_aead_128_tb;
  import laead_pkg::*;

  // Commands with no meaning; the engine takes and drops them
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // Quiet stretch outlasts the longest request (finalize), with some slack
  localparam int unsigned QUIET_CYCLES = 64;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [31:0] data;
    logic        kind;
    logic        last;
    logic        match;
  } result_t;

  // Directed plan row; n_res is the number of results the request must cause
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] word;
    logic [2:0]  cnt;
    logic [63:0] etag;
    logic        good_tag;  // replace etag with the tag the state will give
    logic [1:0]  n_res;
  } plan_row_t;

  localparam int PLAN_LEN = 24;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // unused commands, all-ones and all-zeros payloads
    '{CMD_RSVD6, 32'hFFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0},
    '{CMD_RSVD7, 32'h0000_0000, 3'd0, 64'h0, 1'b0, 2'd0},
    // finalize straight out of reset on the all-zero state
    '{CMD_FINAL, 32'h0000_0000, 3'd4, 64'h0, 1'b1, 2'd2},
    '{CMD_START, 32'hFFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0},
    // nonce ignores byte count, short or not
    '{CMD_NONCE, 32'hFFFF_FFFF, 3'd0, 64'h0, 1'b0, 2'd0},
    '{CMD_NONCE, 32'h0000_0000, 3'd1, 64'h0, 1'b0, 2'd0},
    '{CMD_NONCE, 32'hA5A5_5A5A, 3'd6, 64'h0, 1'b0, 2'd0},
    '{CMD_AD,    32'hFFFF_FFFF, 3'd4, 64'h0, 1'b0, 2'd0},
    '{CMD_AD,    32'h0000_0000, 3'd0, 64'h0, 1'b0, 2'd0},
    '{CMD_AD,    32'h1234_5678, 3'd3, 64'h0, 1'b0, 2'd0},
    '{CMD_ENC,   32'h0000_0000, 3'd4, 64'h0, 1'b0, 2'd1},
    '{CMD_ENC,   32'hFFFF_FFFF, 3'd7, 64'h0, 1'b0, 2'd1},
    '{CMD_ENC,   32'hDEAD_BEEF, 3'd1, 64'h0, 1'b0, 2'd1},
    '{CMD_FINAL, 32'h0000_0000, 3'd4, 64'h0, 1'b1, 2'd2},
    // second finalize back to back, wrong tag
    '{CMD_FINAL, 32'hFFFF_FFFF, 3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd2},
    '{CMD_START, 32'h0000_0000, 3'd0, 64'h0, 1'b0, 2'd0},
    '{CMD_NONCE, 32'h8000_0001, 3'd5, 64'h0, 1'b0, 2'd0},
    '{CMD_AD,    32'h8000_0001, 3'd2, 64'h0, 1'b0, 2'd0},
    '{CMD_DEC,   32'hFFFF_FFFF, 3'd4, 64'h0, 1'b0, 2'd1},
    '{CMD_DEC,   32'h0000_0000, 3'd5, 64'h0, 1'b0, 2'd1},
    '{CMD_DEC,   32'h7FFF_FFFF, 3'd2, 64'h0, 1'b0, 2'd1},
    '{CMD_ENC,   32'hFFFF_FFFF, 3'd3, 64'h0, 1'b0, 2'd1},
    '{CMD_DEC,   32'hC3C3_3C3C, 3'd6, 64'h0, 1'b0, 2'd1},
    '{CMD_FINAL, 32'h0000_0000, 3'd4, 64'h0, 1'b1, 2'd2}
  };

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_addr_i    = CFG_KEY_LOW;
  logic [63:0]           cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [2:0]            s_axis_tuser  = CMD_START;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // Model state: cipher words and key, as the engine should hold them
  logic [31:0] jst [4];
  logic [63:0] key_low_q;
  logic [63:0] key_high_q;

  result_t     pending_results [$];
  int unsigned sent_items = 0;
  int unsigned fail_count = 0;
  int unsigned cycles     = 0;
  bit          calm       = 1'b0;  // no idling on either side while set

  lightweight_aead_128 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------

  // 32 feedback rounds per step; step i mixes in key word i mod 4
  function automatic void advance_state(input int unsigned steps);
    logic [31:0] t47, t70, t85, t91, kw, fb;
    for (int unsigned i = 0; i < steps; i++) begin
      case (i % 4)
        0:       kw = key_low_q[31:0];
        1:       kw = key_low_q[63:32];
        2:       kw = key_high_q[31:0];
        default: kw = key_high_q[63:32];
      endcase
      t47 = (jst[1] >> 15) | (jst[2] << 17);
      t70 = (jst[2] >> 6)  | (jst[3] << 26);
      t85 = (jst[2] >> 21) | (jst[3] << 11);
      t91 = (jst[2] >> 27) | (jst[3] << 5);
      fb  = jst[0] ^ t47 ^ ~(t70 & t85) ^ t91 ^ kw;
      jst[0] = jst[1];
      jst[1] = jst[2];
      jst[2] = jst[3];
      jst[3] = fb;
    end
  endfunction

  // Two-pass tag: long pass for word 0, reframe, short pass for word 1
  function automatic void run_finalize(output logic [31:0] t0, output logic [31:0] t1);
    jst[1] ^= FRAME_FINAL;
    advance_state(STEPS_LONG);
    t0 = jst[2];
    jst[1] ^= FRAME_FINAL;
    advance_state(STEPS_SHORT);
    t1 = jst[2];
  endfunction

  // Tag that a finalize would give now, state left as it was
  function automatic logic [63:0] tag_preview();
    logic [31:0] saved [4];
    logic [31:0] t0, t1;
    saved = jst;
    run_finalize(t0, t1);
    jst = saved;
    return {t1, t0};
  endfunction

  // Applies one accepted request to the model, queues its results
  function automatic int predict_request(input logic [2:0] cmd, input logic [31:0] word,
                                         input logic [2:0] cnt, input logic [63:0] etag);
    logic [31:0] shortlen, mask, w, res, t0, t1;
    shortlen = (cnt >= 3'd1 && cnt <= 3'd3) ? {29'd0, cnt} : 32'd0;
    mask     = (shortlen != 0) ? (32'hFFFF_FFFF >> (8 * (4 - shortlen))) : 32'hFFFF_FFFF;
    w        = word & mask;
    case (cmd)
      CMD_START: begin
        foreach (jst[k]) jst[k] = '0;
        advance_state(STEPS_LONG);
        return 0;
      end
      CMD_NONCE: begin
        // byte count plays no part for nonce words
        jst[1] ^= FRAME_NONCE;
        advance_state(STEPS_SHORT);
        jst[3] ^= word;
        return 0;
      end
      CMD_AD: begin
        jst[1] ^= FRAME_AD;
        advance_state(STEPS_SHORT);
        jst[3] ^= w;
        jst[1] ^= shortlen;
        return 0;
      end
      CMD_ENC, CMD_DEC: begin
        jst[1] ^= FRAME_TEXT;
        advance_state(STEPS_LONG);
        res = (jst[2] ^ w) & mask;
        // encrypt absorbs plaintext, decrypt absorbs the recovered plaintext
        jst[3] ^= (cmd == CMD_ENC) ? w : res;
        jst[1] ^= shortlen;
        pending_results.push_back('{res, KIND_DATA, 1'b1, 1'b0});
        return 1;
      end
      CMD_FINAL: begin
        run_finalize(t0, t1);
        pending_results.push_back('{t0, KIND_TAG, 1'b0, 1'b0});
        pending_results.push_back('{t1, KIND_TAG, 1'b1, ({t1, t0} == etag)});
        return 2;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Drives one request, waits for the handshake, then updates the model
  task automatic push_request(input logic [2:0] cmd, input logic [31:0] word,
                              input logic [2:0] cnt, input logic [63:0] etag,
                              output int n_res);
    if (!calm && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      // mostly short gaps, now and then a long one that can span a whole request
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'd0, etag, cnt, word};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_res = predict_request(cmd, word, cnt, etag);
    if (cmd != CMD_RSVD6 && cmd != CMD_RSVD7) sent_items++;
  endtask

  // Holds off until every queued result has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Key writes only on an idle engine; requests without results may still
  // be running when the queue drains, hence the quiet stretch
  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    settle();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_KEY_LOW;
    cfg_data_i <= lo;
    @(posedge clk_i);
    key_low_q   = lo;
    cfg_addr_i <= CFG_KEY_HIGH;
    cfg_data_i <= hi;
    @(posedge clk_i);
    key_high_q = hi;
    cfg_we_i  <= 1'b0;
  endtask

  // Full word most of the time, odd full-word counts now and then,
  // a short word only at the end of a run
  function automatic logic [2:0] pick_count(input bit is_last);
    if (is_last && $urandom_range(0, 99) < 40) return 3'($urandom_range(1, 3));
    if ($urandom_range(0, 99) < 80) return 3'd4;
    return 3'($urandom_range(5, 8) % 8);
  endfunction

  // One random session: mostly well formed with random content,
  // some noise bursts and sessions with a missing start
  task automatic run_session();
    int          n, n_ad, n_txt;
    logic [2:0]  text_cmd;
    logic [63:0] tag;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4))
        push_request(3'($urandom_range(0, 7)), $urandom, 3'($urandom_range(0, 7)),
                     {$urandom, $urandom}, n);
      return;
    end
    if ($urandom_range(0, 9) != 0)
      push_request(CMD_START, $urandom, 3'($urandom_range(0, 7)), {$urandom, $urandom}, n);
    repeat (3)
      push_request(CMD_NONCE, $urandom, 3'($urandom_range(0, 7)), {$urandom, $urandom}, n);
    n_ad = $urandom_range(0, 4);
    for (int k = 0; k < n_ad; k++)
      push_request(CMD_AD, $urandom, pick_count(k == n_ad - 1), {$urandom, $urandom}, n);
    text_cmd = $urandom_range(0, 1) ? CMD_ENC : CMD_DEC;
    n_txt    = $urandom_range(0, 8);
    for (int k = 0; k < n_txt; k++)
      push_request(text_cmd, $urandom, pick_count(k == n_txt - 1), {$urandom, $urandom}, n);
    if ($urandom_range(0, 9) == 0) settle();
    tag = tag_preview();
    case ($urandom_range(0, 3))
      2:       tag[$urandom_range(0, 63)] ^= 1'b1;  // near miss
      3:       tag = {$urandom, $urandom};
      default: ;
    endcase
    push_request(CMD_FINAL, $urandom, 3'($urandom_range(0, 7)), tag, n);
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: data %h kind %0d last %0d match %0d",
                   got.data, got.kind, got.last, got.match);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: want data %h kind %0d last %0d match %0d, got data %h kind %0d last %0d match %0d",
                     want.data, want.kind, want.last, want.match,
                     got.data, got.kind, got.last, got.match);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    int          n;
    int unsigned target;
    logic [63:0] lo, hi;
    foreach (jst[k]) jst[k] = '0;
    key_low_q  = '0;
    key_high_q = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed plan under the all-zero key
    load_key(64'h0, 64'h0);
    foreach (PLAN[r]) begin
      push_request(PLAN[r].cmd, PLAN[r].word, PLAN[r].cnt,
                   PLAN[r].good_tag ? tag_preview() : PLAN[r].etag, n);
      if (n != int'(PLAN[r].n_res)) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("plan row %0d: %0d results predicted, %0d listed", r, n, PLAN[r].n_res);
      end
    end

    // random phases, one key setting each; phase 2 runs without idling
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin lo = 64'hFFFF_FFFF_FFFF_FFFF; hi = 64'hFFFF_FFFF_FFFF_FFFF; end
        2:       begin lo = 64'h5555_5555_5555_5555; hi = 64'hAAAA_AAAA_AAAA_AAAA; end
        4:       begin lo = 64'hFFFF_FFFF_FFFF_FFFF; hi = 64'h0; end
        default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      endcase
      load_key(lo, hi);
      calm   = (p == 2);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) run_session();
    end
    calm = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: lightweight_aead_128.f
hdl/laead_pkg.sv
hdl/laead_datapath.sv
hdl/laead_ctrl.sv
hdl/lightweight_aead_128.sv
sim/lightweight_aead_128_tb.sv
